/* hw/rtl/tts_pkg.sv */
package tts_pkg;

    localparam int CHAR_W  = 8;
    localparam int COL_W   = 6;
    localparam int ROW_W   = 5;
    localparam int COLOR_W = 4;
    localparam int ESC_W   = 2;
    localparam int TILE_W  = 16;
    localparam int RAW_W   = COL_W + ROW_W + 1;

    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    localparam logic [TILE_W-1:0] BLANK_TILE = 16'h0220;
    localparam logic [CHAR_W-1:0] TAB_CHAR   = 8'h20;
    localparam logic [2:0]        TAB_MASK   = 3'b111;

    localparam logic [CHAR_W-1:0] CC_CLEAR     = 8'h00;
    localparam logic [CHAR_W-1:0] CC_HOME      = 8'h01;
    localparam logic [CHAR_W-1:0] CC_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CC_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CC_COL_PFX   = 8'h0A;
    localparam logic [CHAR_W-1:0] CC_ROW_PFX   = 8'h0B;
    localparam logic [CHAR_W-1:0] CC_COLOR_PFX = 8'h0C;
    localparam logic [CHAR_W-1:0] CC_NEWLINE   = 8'h0D;
    localparam logic [CHAR_W-1:0] CC_LF        = 8'h0A;
    localparam logic [CHAR_W-1:0] CC_CR        = 8'h0D;

    localparam logic OP_CHAR     = 1'b0;
    localparam logic OP_READ     = 1'b1;
    localparam logic MODE_CTRL   = 1'b0;
    localparam logic MODE_STDIO  = 1'b1;

    localparam logic [ESC_W-1:0] ESC_NONE  = 2'd0;
    localparam logic [ESC_W-1:0] ESC_COL   = 2'd1;
    localparam logic [ESC_W-1:0] ESC_ROW   = 2'd2;
    localparam logic [ESC_W-1:0] ESC_COLOR = 2'd3;

    typedef enum logic [3:0] {
        ACT_READ,
        ACT_CLEAR,
        ACT_HOME,
        ACT_BACKSPACE,
        ACT_TAB,
        ACT_NEWLINE,
        ACT_CR,
        ACT_ESC_SET,
        ACT_ESC_APPLY,
        ACT_GLYPH
    } action_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_READ_CAP,
        ST_CLEAR,
        ST_GLYPH,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_SCROLL_FILL,
        ST_DONE
    } state_t;

    typedef enum logic {
        FILL_BLANK,
        FILL_CLEAR
    } fill_sel_t;

    typedef struct packed {
        logic      load_item;
        logic      exec_simple;
        logic      ptr_clr;
        logic      ptr_last_row;
        logic      ptr_inc;
        logic      fill_we;
        fill_sel_t fill_sel;
        logic      copy_rd;
        logic      copy_we;
        logic      rd_tile;
        logic      cap_tile;
        logic      glyph_we;
        logic      newline;
        logic      home;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        action_t action;
        logic    ptr_last;
        logic    copy_last;
        logic    at_bottom;
        logic    col_wrap;
        logic    tab_stop;
        logic    out_free;
    } status_t;

    // remainder by a small constant through a scaled reciprocal
    function automatic logic [COL_W:0] mod_small(input logic [CHAR_W-1:0]  v,
                                                 input logic [COL_W:0]     m,
                                                 input logic [RECIP_W-1:0] recip);
        logic [CHAR_W+RECIP_W-1:0] prod;
        logic [CHAR_W-1:0]         quot;
        logic [CHAR_W+COL_W:0]     back;
        logic [CHAR_W-1:0]         rem;
        prod = (CHAR_W + RECIP_W)'(v) * (CHAR_W + RECIP_W)'(recip);
        quot = prod[RECIP_SHIFT +: CHAR_W];
        back = (CHAR_W + COL_W + 1)'(quot) * (CHAR_W + COL_W + 1)'(m);
        rem  = v - back[CHAR_W-1:0];
        return rem[COL_W:0];
    endfunction

endpackage

/* hw/rtl/text_terminal_screen_writer.sv */
// Text terminal screen writer. Each input word either prints one byte into an
// internal COLUMNS x ROWS store of 16-bit tiles or reads one tile back; every
// word returns exactly one result word with the tile read (zero for a print
// or an out-of-range position) and the cursor, color and pending prefix after
// it. Words are handled one at a time by a controller that steps a datapath
// over a simple dual-port tile RAM (one write and one registered read per cycle).
// A tab prints spaces until the cursor reaches the next tab stop. Clearing the
// screen writes a blank of the current color to every tile. When a line feed
// or a wrap on the bottom row scrolls the screen, the rows are moved up by one,
// tile by tile, and the new bottom row is blanked. After reset the block
// fills the store with blank tiles before it takes its first word;
// configuration writes are taken at any time and must only be issued while
// the block is idle.
module text_terminal_screen_writer
    import tts_pkg::*;
#(
    parameter int COLUMNS = 40,
    parameter int ROWS    = 13
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_terminal_mode,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic [CHAR_W-1:0]  s_char_code,
    input  logic [COL_W-1:0]   s_read_col,
    input  logic [ROW_W-1:0]   s_read_row,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [TILE_W-1:0]  m_tile_data,
    output logic [COL_W-1:0]   m_cursor_col,
    output logic [ROW_W-1:0]   m_cursor_row,
    output logic [COLOR_W-1:0] m_current_color,
    output logic [ESC_W-1:0]   m_escape_pending
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    tts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tts_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .cfg_valid         (cfg_valid),
        .cfg_terminal_mode (cfg_terminal_mode),
        .s_op              (s_op),
        .s_char_code       (s_char_code),
        .s_read_col        (s_read_col),
        .s_read_row        (s_read_row),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_tile_data       (m_tile_data),
        .m_cursor_col      (m_cursor_col),
        .m_cursor_row      (m_cursor_row),
        .m_current_color   (m_current_color),
        .m_escape_pending  (m_escape_pending)
    );

endmodule

/* hw/rtl/tts_ctrl.sv */
module tts_ctrl
    import tts_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd.fill_we  = 1'b1;
                cmd.fill_sel = FILL_BLANK;
                cmd.ptr_inc  = 1'b1;
                if (status.ptr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (status.action)
                    ACT_READ: begin
                        cmd.rd_tile = 1'b1;
                        state_next  = ST_READ_CAP;
                    end
                    ACT_CLEAR: begin
                        cmd.ptr_clr = 1'b1;
                        state_next  = ST_CLEAR;
                    end
                    ACT_GLYPH, ACT_TAB: begin
                        state_next = ST_GLYPH;
                    end
                    ACT_NEWLINE: begin
                        cmd.newline = 1'b1;
                        if (status.at_bottom) begin
                            cmd.ptr_clr = 1'b1;
                            state_next  = ST_SCROLL_RD;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                    default: begin
                        cmd.exec_simple = 1'b1;
                        state_next      = ST_DONE;
                    end
                endcase
            end
            ST_READ_CAP: begin
                cmd.cap_tile = 1'b1;
                state_next   = ST_DONE;
            end
            ST_CLEAR: begin
                cmd.fill_we  = 1'b1;
                cmd.fill_sel = FILL_CLEAR;
                cmd.ptr_inc  = 1'b1;
                if (status.ptr_last) begin
                    cmd.home   = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_GLYPH: begin
                cmd.glyph_we = 1'b1;
                if (status.col_wrap) begin
                    if (status.at_bottom) begin
                        cmd.ptr_clr = 1'b1;
                        state_next  = ST_SCROLL_RD;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else if (status.action != ACT_TAB || status.tab_stop) begin
                    state_next = ST_DONE;
                end
            end
            ST_SCROLL_RD: begin
                cmd.copy_rd = 1'b1;
                state_next  = ST_SCROLL_WR;
            end
            ST_SCROLL_WR: begin
                cmd.copy_we = 1'b1;
                if (status.copy_last) begin
                    cmd.ptr_last_row = 1'b1;
                    state_next       = ST_SCROLL_FILL;
                end else begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = ST_SCROLL_RD;
                end
            end
            ST_SCROLL_FILL: begin
                cmd.fill_we  = 1'b1;
                cmd.fill_sel = FILL_BLANK;
                cmd.ptr_inc  = 1'b1;
                if (status.ptr_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/tts_datapath.sv */
module tts_datapath
    import tts_pkg::*;
#(
    parameter int COLUMNS = 40,
    parameter int ROWS    = 13
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic               cfg_valid,
    input  logic               cfg_terminal_mode,
    input  logic               s_op,
    input  logic [CHAR_W-1:0]  s_char_code,
    input  logic [COL_W-1:0]   s_read_col,
    input  logic [ROW_W-1:0]   s_read_row,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [TILE_W-1:0]  m_tile_data,
    output logic [COL_W-1:0]   m_cursor_col,
    output logic [ROW_W-1:0]   m_cursor_row,
    output logic [COLOR_W-1:0] m_current_color,
    output logic [ESC_W-1:0]   m_escape_pending
);

    localparam int TILES  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(TILES);

    localparam logic [ADDR_W-1:0] LAST_TILE = ADDR_W'(TILES - 1);
    localparam logic [ADDR_W-1:0] LAST_COPY = ADDR_W'(TILES - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW  = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
    localparam logic [RAW_W-1:0]  COLS_RAW  = RAW_W'(COLUMNS);
    localparam logic [COL_W-1:0]  COL_MAX   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_MAX   = ROW_W'(ROWS - 1);
    localparam logic [COL_W:0]    COLS_MOD  = (COL_W + 1)'(COLUMNS);
    localparam logic [COL_W:0]    ROWS_MOD  = (COL_W + 1)'(ROWS);
    localparam logic [RECIP_W-1:0] COLS_RECIP =
        RECIP_W'(((1 << RECIP_SHIFT) + COLUMNS - 1) / COLUMNS);
    localparam logic [RECIP_W-1:0] ROWS_RECIP =
        RECIP_W'(((1 << RECIP_SHIFT) + ROWS - 1) / ROWS);

    logic [TILE_W-1:0] mem [TILES];

    logic               mode_reg;
    logic               op_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [COL_W-1:0]   rcol_reg;
    logic [ROW_W-1:0]   rrow_reg;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [ESC_W-1:0]   esc_reg;
    logic [ADDR_W-1:0]  ptr_reg;
    logic [TILE_W-1:0]  rdata_reg;
    logic [TILE_W-1:0]  tile_reg;
    logic               m_valid_reg;
    logic [TILE_W-1:0]  m_tile_reg;
    logic [COL_W-1:0]   m_col_reg;
    logic [ROW_W-1:0]   m_row_reg;
    logic [COLOR_W-1:0] m_color_reg;
    logic [ESC_W-1:0]   m_esc_reg;

    action_t            action;
    logic [CHAR_W-1:0]  glyph_char;
    logic [TILE_W-1:0]  glyph_tile;
    logic [TILE_W-1:0]  clear_tile;
    logic [RAW_W-1:0]   cur_raw;
    logic [RAW_W-1:0]   item_raw;
    logic               item_in_range;
    logic [ADDR_W-1:0]  rd_addr;
    logic               rd_en;
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [TILE_W-1:0]  wdata;
    logic [COL_W-1:0]   col_plus;
    logic               col_wrap;
    logic               at_bottom;
    logic [ESC_W-1:0]   esc_code;
    logic [COL_W:0]     col_mod;
    logic [COL_W:0]     row_mod;

    always_comb begin
        action = ACT_GLYPH;
        if (op_reg == OP_READ) begin
            action = ACT_READ;
        end else if (mode_reg == MODE_CTRL) begin
            if (esc_reg != ESC_NONE) begin
                action = ACT_ESC_APPLY;
            end else begin
                case (char_reg)
                    CC_CLEAR:     action = ACT_CLEAR;
                    CC_HOME:      action = ACT_HOME;
                    CC_BACKSPACE: action = ACT_BACKSPACE;
                    CC_TAB:       action = ACT_TAB;
                    CC_COL_PFX:   action = ACT_ESC_SET;
                    CC_ROW_PFX:   action = ACT_ESC_SET;
                    CC_COLOR_PFX: action = ACT_ESC_SET;
                    CC_NEWLINE:   action = ACT_NEWLINE;
                    default:      action = ACT_GLYPH;
                endcase
            end
        end else begin
            case (char_reg)
                CC_BACKSPACE: action = ACT_BACKSPACE;
                CC_TAB:       action = ACT_TAB;
                CC_LF:        action = ACT_NEWLINE;
                CC_CR:        action = ACT_CR;
                default:      action = ACT_GLYPH;
            endcase
        end
    end

    always_comb begin
        case (char_reg)
            CC_COL_PFX: esc_code = ESC_COL;
            CC_ROW_PFX: esc_code = ESC_ROW;
            default:    esc_code = ESC_COLOR;
        endcase
    end

    assign glyph_char = (action == ACT_TAB) ? TAB_CHAR : char_reg;
    assign glyph_tile = {1'b0, color_reg, glyph_char[0], 1'b1, 1'b0,
                         glyph_char[CHAR_W-1:1], 1'b0};
    assign clear_tile = {1'b0, color_reg, BLANK_TILE[TILE_W-COLOR_W-2:0]};

    assign cur_raw  = RAW_W'(row_reg) * COLS_RAW + RAW_W'(col_reg);
    assign item_raw = RAW_W'(rrow_reg) * COLS_RAW + RAW_W'(rcol_reg);
    assign item_in_range = (rcol_reg <= COL_MAX) && (rrow_reg <= ROW_MAX)
                           && (RAW_W'(rcol_reg) < COLS_RAW);

    assign col_mod = mod_small(char_reg, COLS_MOD, COLS_RECIP);
    assign row_mod = mod_small(char_reg, ROWS_MOD, ROWS_RECIP);

    assign col_plus  = col_reg + COL_W'(1);
    assign col_wrap  = (col_reg == COL_MAX);
    assign at_bottom = (row_reg == ROW_MAX);

    assign rd_en   = cmd.copy_rd | cmd.rd_tile;
    assign rd_addr = cmd.copy_rd ? ptr_reg + ROW_STEP : item_raw[ADDR_W-1:0];

    always_comb begin
        we    = 1'b0;
        waddr = ptr_reg;
        wdata = BLANK_TILE;
        if (cmd.fill_we) begin
            we    = 1'b1;
            wdata = (cmd.fill_sel == FILL_CLEAR) ? clear_tile : BLANK_TILE;
        end else if (cmd.copy_we) begin
            we    = 1'b1;
            wdata = rdata_reg;
        end else if (cmd.glyph_we) begin
            we    = 1'b1;
            waddr = cur_raw[ADDR_W-1:0];
            wdata = glyph_tile;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
        end else if (cmd.ptr_clr) begin
            ptr_reg <= '0;
        end else if (cmd.ptr_last_row) begin
            ptr_reg <= LAST_ROW;
        end else if (cmd.ptr_inc) begin
            ptr_reg <= ptr_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_CTRL;
        end else if (cfg_valid) begin
            mode_reg <= cfg_terminal_mode;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg   <= s_op;
            char_reg <= s_char_code;
            rcol_reg <= s_read_col;
            rrow_reg <= s_read_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            tile_reg <= '0;
        end else if (cmd.cap_tile) begin
            tile_reg <= item_in_range ? rdata_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            color_reg <= '0;
            esc_reg   <= ESC_NONE;
        end else if (cmd.exec_simple) begin
            case (action)
                ACT_HOME: begin
                    col_reg <= '0;
                    row_reg <= '0;
                end
                ACT_BACKSPACE: begin
                    if (col_reg != '0) begin
                        col_reg <= col_reg - COL_W'(1);
                    end
                end
                ACT_CR: begin
                    col_reg <= '0;
                end
                ACT_ESC_SET: begin
                    esc_reg <= esc_code;
                end
                ACT_ESC_APPLY: begin
                    case (esc_reg)
                        ESC_COL: col_reg   <= col_mod[COL_W-1:0];
                        ESC_ROW: row_reg   <= row_mod[ROW_W-1:0];
                        default: color_reg <= char_reg[COLOR_W-1:0];
                    endcase
                    esc_reg <= ESC_NONE;
                end
                default: begin
                    esc_reg <= esc_reg;
                end
            endcase
        end else if (cmd.glyph_we) begin
            if (col_wrap) begin
                col_reg <= '0;
                if (!at_bottom) begin
                    row_reg <= row_reg + ROW_W'(1);
                end
            end else begin
                col_reg <= col_plus;
            end
        end else if (cmd.newline) begin
            col_reg <= '0;
            if (!at_bottom) begin
                row_reg <= row_reg + ROW_W'(1);
            end
        end else if (cmd.home) begin
            col_reg <= '0;
            row_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tile_reg  <= tile_reg;
            m_col_reg   <= col_reg;
            m_row_reg   <= row_reg;
            m_color_reg <= color_reg;
            m_esc_reg   <= esc_reg;
        end
    end

    assign status.action    = action;
    assign status.ptr_last  = (ptr_reg == LAST_TILE);
    assign status.copy_last = (ptr_reg == LAST_COPY);
    assign status.at_bottom = at_bottom;
    assign status.col_wrap  = col_wrap;
    assign status.tab_stop  = ((col_plus[2:0] & TAB_MASK) == 3'b000);
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid          = m_valid_reg;
    assign m_tile_data      = m_tile_reg;
    assign m_cursor_col     = m_col_reg;
    assign m_cursor_row     = m_row_reg;
    assign m_current_color  = m_color_reg;
    assign m_escape_pending = m_esc_reg;

endmodule

/* dv/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tts_pkg::*;

    localparam int COLUMNS        = 40;
    localparam int ROWS           = 13;
    localparam int TILES          = COLUMNS * ROWS;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct {
        logic [TILE_W-1:0]  tile;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [COLOR_W-1:0] color;
        logic [ESC_W-1:0]   esc;
    } terminal_word_t;

    logic               aclk              = 1'b0;
    logic               aresetn           = 1'b0;
    logic               cfg_valid         = 1'b0;
    logic               cfg_ready;
    logic               cfg_terminal_mode = MODE_CTRL;
    logic               s_valid           = 1'b0;
    logic               s_ready;
    logic               s_op              = OP_CHAR;
    logic [CHAR_W-1:0]  s_char_code       = '0;
    logic [COL_W-1:0]   s_read_col        = '0;
    logic [ROW_W-1:0]   s_read_row        = '0;
    logic               m_valid;
    logic               m_ready           = 1'b0;
    logic [TILE_W-1:0]  m_tile_data;
    logic [COL_W-1:0]   m_cursor_col;
    logic [ROW_W-1:0]   m_cursor_row;
    logic [COLOR_W-1:0] m_current_color;
    logic [ESC_W-1:0]   m_escape_pending;

    int unsigned tx_idle_pct   = 0;
    int unsigned rx_stall_pct  = 0;
    logic        rx_hold_req   = 1'b0;
    int unsigned quiet_cycles  = 0;
    int unsigned mismatch_count = 0;

    terminal_word_t awaited_words[$];
    terminal_word_t due_word;

    logic [TILE_W-1:0]  screen_copy [TILES];
    int unsigned        cur_col;
    int unsigned        cur_row;
    logic [COLOR_W-1:0] cur_color;
    logic [ESC_W-1:0]   cur_esc;
    logic               cur_mode;

    text_terminal_screen_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_terminal_mode (cfg_terminal_mode),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_char_code       (s_char_code),
        .s_read_col        (s_read_col),
        .s_read_row        (s_read_row),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_tile_data       (m_tile_data),
        .m_cursor_col      (m_cursor_col),
        .m_cursor_row      (m_cursor_row),
        .m_current_color   (m_current_color),
        .m_escape_pending  (m_escape_pending)
    );

    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    // ---------------- screen predictor ----------------

    function automatic void feed_line();
        cur_col = 0;
        if (cur_row + 1 >= ROWS) begin
            for (int i = 0; i < TILES - COLUMNS; i++) begin
                screen_copy[i] = screen_copy[i + COLUMNS];
            end
            for (int i = TILES - COLUMNS; i < TILES; i++) begin
                screen_copy[i] = BLANK_TILE;
            end
        end else begin
            cur_row++;
        end
    endfunction

    function automatic void draw_glyph(input logic [CHAR_W-1:0] c);
        screen_copy[cur_row * COLUMNS + cur_col] = {1'b0, cur_color, c[0], 2'b10, c[7:1], 1'b0};
        cur_col++;
        if (cur_col >= COLUMNS) begin
            feed_line();
        end
    endfunction

    function automatic void tab_out();
        do begin
            draw_glyph(TAB_CHAR);
        end while ((cur_col & TAB_MASK) != 0);
    endfunction

    function automatic void back_up();
        if (cur_col != 0) begin
            cur_col--;
        end
    endfunction

    function automatic terminal_word_t screen_step(input logic              op,
                                                   input logic [CHAR_W-1:0] c,
                                                   input logic [COL_W-1:0]  rc,
                                                   input logic [ROW_W-1:0]  rr);
        terminal_word_t w;
        w.tile = '0;
        if (op == OP_READ) begin
            if (rc < COLUMNS && rr < ROWS) begin
                w.tile = screen_copy[rr * COLUMNS + rc];
            end
        end else if (cur_mode == MODE_CTRL) begin
            if (cur_esc != ESC_NONE) begin
                case (cur_esc)
                    ESC_COL: cur_col   = c % COLUMNS;
                    ESC_ROW: cur_row   = c % ROWS;
                    default: cur_color = c[COLOR_W-1:0];
                endcase
                cur_esc = ESC_NONE;
            end else begin
                case (c)
                    CC_CLEAR: begin
                        for (int i = 0; i < TILES; i++) begin
                            screen_copy[i] = {1'b0, cur_color, BLANK_TILE[10:0]};
                        end
                        cur_col = 0;
                        cur_row = 0;
                    end
                    CC_HOME: begin
                        cur_col = 0;
                        cur_row = 0;
                    end
                    CC_BACKSPACE: back_up();
                    CC_TAB:       tab_out();
                    CC_COL_PFX:   cur_esc = ESC_COL;
                    CC_ROW_PFX:   cur_esc = ESC_ROW;
                    CC_COLOR_PFX: cur_esc = ESC_COLOR;
                    CC_NEWLINE:   feed_line();
                    default:      draw_glyph(c);
                endcase
            end
        end else begin
            case (c)
                CC_BACKSPACE: back_up();
                CC_TAB:       tab_out();
                CC_LF:        feed_line();
                CC_CR:        cur_col = 0;
                default:      draw_glyph(c);
            endcase
        end
        w.col   = COL_W'(cur_col);
        w.row   = ROW_W'(cur_row);
        w.color = cur_color;
        w.esc   = cur_esc;
        return w;
    endfunction

    // ---------------- result checking ----------------

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (awaited_words.size() == 0) begin
                $error("result word with nothing expected");
                mismatch_count++;
            end else begin
                due_word = awaited_words.pop_front();
                check_field("tile_data", due_word.tile, m_tile_data);
                check_field("cursor_col", due_word.col, m_cursor_col);
                check_field("cursor_row", due_word.row, m_cursor_row);
                check_field("current_color", due_word.color, m_current_color);
                check_field("escape_pending", due_word.esc, m_escape_pending);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no word accepted for %0d cycles", quiet_cycles);
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver: random stalls, long hold on request
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ---------------- stimulus ----------------

    task automatic send_word(input logic              op,
                             input logic [CHAR_W-1:0] c,
                             input logic [COL_W-1:0]  rc,
                             input logic [ROW_W-1:0]  rr);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_op        <= op;
        s_char_code <= c;
        s_read_col  <= rc;
        s_read_row  <= rr;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        awaited_words.push_back(screen_step(op, c, rc, rr));
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] c);
        send_word(OP_CHAR, c, COL_W'($urandom), ROW_W'($urandom));
    endtask

    task automatic read_tile(input logic [COL_W-1:0] rc, input logic [ROW_W-1:0] rr);
        send_word(OP_READ, CHAR_W'($urandom), rc, rr);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (awaited_words.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input logic m);
        wait_drained();
        cfg_valid         <= 1'b1;
        cfg_terminal_mode <= m;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_mode = m;
    endtask

    task automatic test_blank_reads();
        read_tile(COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1));
        read_tile(COL_W'(COLUMNS), ROW_W'(ROWS - 1));
        read_tile(COL_W'(COLUMNS - 1), ROW_W'(ROWS));
        read_tile('1, '1);
    endtask

    task automatic test_control_codes();
        put_char(CC_COLOR_PFX);
        put_char(8'hFF);
        put_char(8'hFF);
        put_char(CC_BACKSPACE);
        put_char(CC_BACKSPACE);
        put_char(CC_TAB);
        put_char(CC_HOME);
        put_char(CC_COL_PFX);
        put_char(8'hFF);
        put_char(CC_ROW_PFX);
        put_char(8'hFF);
        put_char(CC_NEWLINE);
        put_char(CC_CLEAR);
        put_char(CC_COLOR_PFX);
        put_char(8'h00);
        read_tile('0, '0);
    endtask

    task automatic test_tab_wrap_scroll();
        put_char(CC_COL_PFX);
        put_char(CHAR_W'(COLUMNS - 2));
        put_char(CC_ROW_PFX);
        put_char(CHAR_W'(ROWS - 1));
        put_char(CC_TAB);
        read_tile(COL_W'(COLUMNS - 1), ROW_W'(ROWS - 2));
        read_tile('0, ROW_W'(ROWS - 1));
    endtask

    task automatic test_stdio_codes();
        put_char(CC_ROW_PFX);
        write_mode(MODE_STDIO);
        put_char(8'h00);
        put_char(CC_ROW_PFX);
        put_char(CC_COLOR_PFX);
        put_char(CC_BACKSPACE);
        put_char(CC_TAB);
        put_char(CC_LF);
        put_char(CC_CR);
        read_tile('0, '0);
        write_mode(MODE_CTRL);
        put_char(8'h05);
    endtask

    task automatic test_output_backpressure();
        wait_drained();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_req  = 1'b1;
        repeat (16) begin
            if ($urandom_range(1) == 0) begin
                put_char(CHAR_W'($urandom_range(8'h20, 8'hFF)));
            end else begin
                read_tile(COL_W'($urandom_range(COLUMNS - 1)), ROW_W'($urandom_range(ROWS - 1)));
            end
        end
        wait_drained();
    endtask

    task automatic test_random_traffic(input int items, input int unsigned tx_pct,
                                       input int unsigned rx_pct, input logic m);
        int          sent;
        int unsigned pick;
        int          run;
        write_mode(m);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                if ($urandom_range(4) == 0) begin
                    read_tile(COL_W'($urandom), ROW_W'($urandom));
                end else begin
                    read_tile(COL_W'($urandom_range(COLUMNS - 1)),
                              ROW_W'($urandom_range(ROWS - 1)));
                end
                sent++;
            end else if (pick < 55) begin
                run = $urandom_range(1, 12);
                repeat (run) put_char(CHAR_W'($urandom_range(8'h20, 8'hFF)));
                sent += run;
            end else if (pick < 70) begin
                case ($urandom_range(2))
                    0:       put_char(CC_COL_PFX);
                    1:       put_char(CC_ROW_PFX);
                    default: put_char(CC_COLOR_PFX);
                endcase
                put_char(CHAR_W'($urandom));
                sent += 2;
            end else if (pick < 92) begin
                if (cur_mode == MODE_CTRL) begin
                    case ($urandom_range(3))
                        0:       put_char(CC_HOME);
                        1:       put_char(CC_BACKSPACE);
                        2:       put_char(CC_TAB);
                        default: put_char(CC_NEWLINE);
                    endcase
                end else begin
                    case ($urandom_range(3))
                        0:       put_char(CC_BACKSPACE);
                        1:       put_char(CC_TAB);
                        2:       put_char(CC_LF);
                        default: put_char(CC_CR);
                    endcase
                end
                sent++;
            end else if (pick < 93) begin
                put_char(CC_CLEAR);
                sent++;
            end else begin
                put_char(CHAR_W'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        for (int i = 0; i < TILES; i++) begin
            screen_copy[i] = BLANK_TILE;
        end
        cur_col   = 0;
        cur_row   = 0;
        cur_color = '0;
        cur_esc   = ESC_NONE;
        cur_mode  = MODE_CTRL;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        write_mode(MODE_CTRL);
        test_blank_reads();
        test_control_codes();
        test_tab_wrap_scroll();
        test_stdio_codes();
        test_output_backpressure();
        test_random_traffic(350, 0, 0, MODE_CTRL);
        test_random_traffic(350, 80, 0, MODE_STDIO);
        test_random_traffic(350, 0, 80, MODE_CTRL);
        test_random_traffic(350, 35, 35, MODE_STDIO);
        wait_drained();

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
